// ===== hw/rtl/bcdclk_pkg.sv =====
// Shared types, codes and digit helpers for the BCD clock register port.
package bcdclk_pkg;

  // Operation carried in the low bits of the input tuser.
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_BUSY  = 2'd3
  } action_t;

  // Port selector carried above the operation in tuser.
  typedef enum logic {
    PORT_DATA = 1'b0,
    PORT_CMD  = 1'b1
  } port_t;

  typedef logic [3:0] nibble_t;

  localparam int unsigned NumNibbles  = 16;
  localparam int unsigned InDataWidth = 48;
  localparam int unsigned InUserWidth = 3;

  localparam logic [3:0] RegHourTens = 4'd5;
  localparam logic [3:0] RegDayTens  = 4'd8;
  localparam logic [4:0] LastAmHour  = 5'd11;
  localparam logic [7:0] ReadyBit    = 8'h80;

  // Quotient by ten for values up to 127, through a reciprocal multiply.
  function automatic nibble_t div10(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  // Remainder by ten for values up to 127.
  function automatic nibble_t mod10(input logic [6:0] v);
    logic [6:0] r;
    r = v - 7'({3'b000, div10(v)} * 7'd10);
    return r[3:0];
  endfunction

endpackage

// ===== hw/rtl/bcd_clock_chip_register_port.sv =====
// Top level of the BCD clock register port: port decode, nibble store and result register.
//
// The block models a clock chip reached through a data port and a command port.
// Items arrive on the in_ stream: in_tuser selects the operation (port write, port
// read, time tick, busy level) and the port, in_tdata carries the byte and the host
// time. Only a port read produces a result, which leaves on the out_ stream as one
// byte: the command latch for the command port, or the read nibble with a ready bit
// in bit 7 (set while the busy level is low) for the data port.
//
// Each accepted transfer lands in an input register; from there short decode logic
// updates the latches and nibble registers and, for a read, loads the result register.
// A read therefore passes the input register and then the result register before it
// shows on out_tvalid, and one item is taken in every cycle while the result side keeps up.
//
// Synchronous reset clears all latches, the sixteen nibble registers and both valid
// flags. When the receiver stalls, the result register holds its byte; the input
// register still drains writes, ticks and busy updates, and only a pending read
// waits, which then lowers in_tready until the result register is free again.
module bcd_clock_chip_register_port (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: data[7:0], busy_flag[8], year_in_century[15:9], month[19:16],
  // day[24:20], weekday[27:25], hour[32:28], minute[38:33], second[44:39], zero pad.
  input  logic [47:0] in_tdata,
  // Fields from bit 0: action[1:0], port[2].
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: read_data[7:0].
  output logic [7:0]  out_tdata
);

  // Input register.
  logic                                        s1_valid_r;
  logic [bcdclk_pkg::InDataWidth-1:0]          s1_data_r;
  logic [bcdclk_pkg::InUserWidth-1:0]          s1_user_r;

  // Architectural state.
  bcdclk_pkg::nibble_t nib_r   [bcdclk_pkg::NumNibbles];
  bcdclk_pkg::nibble_t nib_nxt [bcdclk_pkg::NumNibbles];
  logic [7:0]          wr_latch_r, wr_latch_nxt;
  logic [3:0]          rd_latch_r, rd_latch_nxt;
  logic [7:0]          cmd_r, cmd_nxt;
  logic [3:0]          sel_r, sel_nxt;
  logic                busy_r, busy_nxt;

  // Result register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;

  bcdclk_pkg::action_t act;
  bcdclk_pkg::port_t   prt;
  logic [7:0]          f_data;
  logic [6:0]          f_year;
  logic [3:0]          f_month;
  logic [4:0]          f_day;
  logic [2:0]          f_wday;
  logic [4:0]          f_hour;
  logic [5:0]          f_min;
  logic [5:0]          f_sec;
  logic                f_busy;

  logic       advance;
  logic [4:0] shown_hour;
  logic [6:0] year_mod;
  logic       pm;

  assign act     = bcdclk_pkg::action_t'(s1_user_r[1:0]);
  assign prt     = bcdclk_pkg::port_t'(s1_user_r[2]);
  assign f_data  = s1_data_r[7:0];
  assign f_busy  = s1_data_r[8];
  assign f_year  = s1_data_r[15:9];
  assign f_month = s1_data_r[19:16];
  assign f_day   = s1_data_r[24:20];
  assign f_wday  = s1_data_r[27:25];
  assign f_hour  = s1_data_r[32:28];
  assign f_min   = s1_data_r[38:33];
  assign f_sec   = s1_data_r[44:39];

  // A held item moves on unless it is a read facing a full, stalled result register.
  assign advance   = s1_valid_r &&
                     ((act != bcdclk_pkg::ACT_READ) || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Unless hour-tens bit 3 is set, hours up to 31 wrap at twelve, minus 24 or 12.
  always_comb begin
    pm = (f_hour > bcdclk_pkg::LastAmHour);
    if (nib_r[bcdclk_pkg::RegHourTens][3]) begin
      shown_hour = f_hour;
    end else if (f_hour >= 5'd24) begin
      shown_hour = f_hour - 5'd24;
    end else if (f_hour >= 5'd12) begin
      shown_hour = f_hour - 5'd12;
    end else begin
      shown_hour = f_hour;
    end
    year_mod = (f_year >= 7'd100) ? (f_year - 7'd100) : f_year;
  end

  always_comb begin
    nib_nxt       = nib_r;
    wr_latch_nxt  = wr_latch_r;
    rd_latch_nxt  = rd_latch_r;
    cmd_nxt       = cmd_r;
    sel_nxt       = sel_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (advance) begin
      case (act)
        bcdclk_pkg::ACT_WRITE: begin
          if (prt == bcdclk_pkg::PORT_CMD) begin
            // Edges are judged against the previous command byte, only with chip select.
            if (f_data[7]) begin
              if (!cmd_r[2] && f_data[2]) begin
                rd_latch_nxt = nib_r[sel_r];
              end
              if (cmd_r[1] && !f_data[1]) begin
                if (sel_r == bcdclk_pkg::RegHourTens) begin
                  nib_nxt[bcdclk_pkg::RegHourTens] =
                    {wr_latch_r[3], nib_r[bcdclk_pkg::RegHourTens][2:0]};
                end else if (sel_r == bcdclk_pkg::RegDayTens) begin
                  nib_nxt[bcdclk_pkg::RegDayTens] =
                    {wr_latch_r[3:2], nib_r[bcdclk_pkg::RegDayTens][1:0]};
                end
              end
              if (cmd_r[0] && !f_data[0]) begin
                sel_nxt = wr_latch_r[3:0];
              end
            end
            cmd_nxt = f_data;
          end else begin
            wr_latch_nxt = f_data;
          end
        end
        bcdclk_pkg::ACT_READ: begin
          out_valid_nxt = 1'b1;
          if (prt == bcdclk_pkg::PORT_CMD) begin
            out_data_nxt = cmd_r;
          end else begin
            out_data_nxt = {4'b0000, rd_latch_r} | (busy_r ? 8'h00 : bcdclk_pkg::ReadyBit);
          end
        end
        bcdclk_pkg::ACT_TICK: begin
          nib_nxt[0]  = bcdclk_pkg::mod10({1'b0, f_sec});
          nib_nxt[1]  = bcdclk_pkg::div10({1'b0, f_sec});
          nib_nxt[2]  = bcdclk_pkg::mod10({1'b0, f_min});
          nib_nxt[3]  = bcdclk_pkg::div10({1'b0, f_min});
          nib_nxt[4]  = bcdclk_pkg::mod10({2'b00, shown_hour});
          nib_nxt[5]  = bcdclk_pkg::div10({2'b00, shown_hour}) |
                        {nib_r[bcdclk_pkg::RegHourTens][3], pm, 2'b00};
          nib_nxt[6]  = {1'b0, f_wday};
          nib_nxt[7]  = bcdclk_pkg::mod10({2'b00, f_day});
          nib_nxt[8]  = bcdclk_pkg::div10({2'b00, f_day}) |
                        {nib_r[bcdclk_pkg::RegDayTens][3:2], 2'b00};
          nib_nxt[9]  = bcdclk_pkg::mod10({3'b000, f_month});
          nib_nxt[10] = bcdclk_pkg::div10({3'b000, f_month});
          nib_nxt[11] = bcdclk_pkg::mod10(f_year);
          nib_nxt[12] = bcdclk_pkg::div10(year_mod);
        end
        bcdclk_pkg::ACT_BUSY: begin
          busy_nxt = f_busy;
        end
        default: begin
          busy_nxt = busy_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      wr_latch_r  <= '0;
      rd_latch_r  <= '0;
      cmd_r       <= '0;
      sel_r       <= '0;
      busy_r      <= 1'b0;
      for (int i = 0; i < bcdclk_pkg::NumNibbles; i++) begin
        nib_r[i] <= '0;
      end
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      out_valid_r <= out_valid_nxt;
      wr_latch_r  <= wr_latch_nxt;
      rd_latch_r  <= rd_latch_nxt;
      cmd_r       <= cmd_nxt;
      sel_r       <= sel_nxt;
      busy_r      <= busy_nxt;
      nib_r       <= nib_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
      s1_user_r <= in_tuser;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== hw/rtl/bcdclk_checker.sv =====
// Port-level checker for the BCD clock register port and its bind.
module bcdclk_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // No result is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // The input side only pushes back while a result is stuck at the output.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a stalled result");

  // A read that enters while the output is empty shows up after the input and result registers.
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser[1:0] == bcdclk_pkg::ACT_READ) && !out_tvalid)
    |-> ##2 out_tvalid)
    else $error("read result missing after two cycles");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("result changed while stalled");

endmodule

bind bcd_clock_chip_register_port bcdclk_checker u_bcdclk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
